// ===== rtl/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_SEARCH = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_POS  = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    localparam int KEY_W = 32;
    localparam int GROUP_W = 8;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [7:0]              position;
        logic signed [KEY_W-1:0] key;
    } pal_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [6:0]              found_index;
        logic signed [KEY_W-1:0] entry_key;
        logic [7:0]              entry_count;
    } pal_rsp_t;

    typedef struct packed {
        logic ins;
        logic rem;
        logic srch;
    } pal_op_t;

endpackage

// ===== rtl/pal_cell.sv =====
`timescale 1ns / 1ps

module pal_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pal_pkg::pal_op_t               op,
    input  logic [CW-1:0]                  pos,
    input  logic [CW-1:0]                  count,
    input  logic signed [pal_pkg::KEY_W-1:0] key_in,
    input  logic signed [pal_pkg::KEY_W-1:0] left_key,
    input  logic signed [pal_pkg::KEY_W-1:0] right_key,
    output logic signed [pal_pkg::KEY_W-1:0] key_out,
    output logic signed [pal_pkg::KEY_W-1:0] rem_key,
    output logic                           match
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [pal_pkg::KEY_W-1:0] key_reg;
    logic signed [pal_pkg::KEY_W-1:0] key_next;
    logic                             match_reg;
    logic                             match_next;
    logic                             at_pos;

    assign at_pos = (MY_IDX == pos);

    always_comb
    begin
        key_next = key_reg;
        if (op.ins)
        begin
            if (at_pos)
            begin
                key_next = key_in;
            end
            else if (MY_IDX > pos)
            begin
                key_next = left_key;
            end
        end
        else if (op.rem)
        begin
            if (MY_IDX >= pos)
            begin
                key_next = right_key;
            end
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (op.srch)
        begin
            match_next = (key_reg == key_in) && (MY_IDX < count);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign key_out = key_reg;
    assign rem_key = at_pos ? key_reg : '0;
    assign match   = match_reg;

endmodule

// ===== rtl/positional_array_list.sv =====
`timescale 1ns / 1ps
// Clear, insert and remove finish at once: the result strobes in the cycle after the transfer
// and busy stays low, so a new command may follow at once.
// Search: the cells compare the key into registered match flags, then the match
// flags are scanned eight cells per cycle, lowest first; busy is high meanwhile.
// The receiver cannot stall; every result is valid for exactly one cycle on done.
// Reset empties the list and clears the control state; stored keys are not cleared.
module positional_array_list #(
    parameter int CAPACITY = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pal_pkg::pal_req_t req,
    output logic              done,
    output pal_pkg::pal_rsp_t rsp
);

    localparam int CNTW   = $clog2(CAPACITY + 1);
    localparam int CW     = (CNTW > 8) ? CNTW : 8;
    localparam int GROUPS = (CAPACITY + pal_pkg::GROUP_W - 1) / pal_pkg::GROUP_W;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int OFFW   = $clog2(pal_pkg::GROUP_W);
    localparam int FW     = GW + OFFW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                             state_reg;
    logic                             state_next;
    logic [CNTW-1:0]                  count_reg;
    logic [CNTW-1:0]                  count_next;
    logic [GW-1:0]                    grp_reg;
    logic [GW-1:0]                    grp_next;
    logic signed [pal_pkg::KEY_W-1:0] skey_reg;
    logic signed [pal_pkg::KEY_W-1:0] skey_next;
    logic                             done_reg;
    logic                             done_next;
    pal_pkg::pal_rsp_t                rsp_reg;
    pal_pkg::pal_rsp_t                rsp_next;

    pal_pkg::pal_op_t                 op;
    logic [CW-1:0]                    pos_w;
    logic [CW-1:0]                    cnt_w;
    logic                             accept;
    logic                             full;

    logic signed [pal_pkg::KEY_W-1:0] cell_key [CAPACITY];
    logic signed [pal_pkg::KEY_W-1:0] cell_rem [CAPACITY];
    logic [GROUPS*pal_pkg::GROUP_W-1:0] match_vec;
    logic signed [pal_pkg::KEY_W-1:0] removed_key;

    logic [pal_pkg::GROUP_W-1:0]      grp_bits;
    logic                             grp_hit;
    logic [OFFW-1:0]                  grp_off;
    logic [FW-1:0]                    hit_idx;

    assign accept = start && (state_reg == ST_IDLE);
    assign pos_w  = CW'(req.position);
    assign cnt_w  = CW'(count_reg);
    assign full   = (cnt_w >= CW'(CAPACITY));

    always_comb
    begin
        op = '0;
        if (accept)
        begin
            unique case (req.cmd)
                pal_pkg::CMD_INSERT: op.ins  = !full && (pos_w <= cnt_w);
                pal_pkg::CMD_REMOVE: op.rem  = (pos_w < cnt_w);
                pal_pkg::CMD_SEARCH: op.srch = 1'b1;
                default:             op      = '0;
            endcase
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [pal_pkg::KEY_W-1:0] left_k;
            logic signed [pal_pkg::KEY_W-1:0] right_k;

            if (i == 0)
            begin : g_first
                assign left_k = '0;
            end
            else
            begin : g_mid_l
                assign left_k = cell_key[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_k = '0;
            end
            else
            begin : g_mid_r
                assign right_k = cell_key[i+1];
            end

            pal_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .pos       (pos_w),
                .count     (cnt_w),
                .key_in    (req.key),
                .left_key  (left_k),
                .right_key (right_k),
                .key_out   (cell_key[i]),
                .rem_key   (cell_rem[i]),
                .match     (match_vec[i])
            );
        end

        if (GROUPS * pal_pkg::GROUP_W > CAPACITY)
        begin : g_pad
            assign match_vec[GROUPS*pal_pkg::GROUP_W-1:CAPACITY] = '0;
        end
    endgenerate

    always_comb
    begin
        removed_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed_key = removed_key | cell_rem[i];
        end
    end

    assign grp_bits = match_vec[grp_reg*pal_pkg::GROUP_W +: pal_pkg::GROUP_W];
    assign grp_hit  = |grp_bits;

    always_comb
    begin
        grp_off = '0;
        for (int b = pal_pkg::GROUP_W - 1; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                grp_off = OFFW'(b);
            end
        end
    end

    assign hit_idx = {grp_reg, grp_off};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        grp_next   = grp_reg;
        skey_next  = skey_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status      = pal_pkg::STATUS_OK;
                    rsp_next.found_index = '0;
                    rsp_next.entry_key   = '0;
                    unique case (req.cmd)
                        pal_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        pal_pkg::CMD_INSERT:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                rsp_next.status = pal_pkg::STATUS_FULL;
                            end
                            else if (pos_w > cnt_w)
                            begin
                                rsp_next.status = pal_pkg::STATUS_BAD_POS;
                            end
                            else
                            begin
                                count_next         = count_reg + CNTW'(1);
                                rsp_next.entry_key = req.key;
                            end
                        end
                        pal_pkg::CMD_REMOVE:
                        begin
                            done_next = 1'b1;
                            if (pos_w >= cnt_w)
                            begin
                                rsp_next.status = pal_pkg::STATUS_BAD_POS;
                            end
                            else
                            begin
                                count_next         = count_reg - CNTW'(1);
                                rsp_next.entry_key = removed_key;
                            end
                        end
                        pal_pkg::CMD_SEARCH:
                        begin
                            state_next = ST_SCAN;
                            grp_next   = '0;
                            skey_next  = req.key;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                    rsp_next.entry_count = 8'(count_next);
                end
            end
            ST_SCAN:
            begin
                if (grp_hit)
                begin
                    state_next           = ST_IDLE;
                    done_next            = 1'b1;
                    rsp_next.status      = pal_pkg::STATUS_OK;
                    rsp_next.found_index = 7'(hit_idx);
                    rsp_next.entry_key   = skey_reg;
                end
                else if (grp_reg == GW'(GROUPS - 1))
                begin
                    state_next           = ST_IDLE;
                    done_next            = 1'b1;
                    rsp_next.status      = pal_pkg::STATUS_NOT_FOUND;
                    rsp_next.found_index = '0;
                    rsp_next.entry_key   = '0;
                end
                else
                begin
                    grp_next = grp_reg + GW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            grp_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            grp_reg   <= grp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skey_reg <= skey_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== tb/positional_array_list_tb.sv =====
`timescale 1ns / 1ps

module positional_array_list_tb;

    localparam int CAPACITY = 128;
    localparam int RANDOM_OPS = 800;
    localparam int PHASE_LEN = 100;
    localparam int QUIET_TAIL = 120;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    pal_pkg::pal_req_t req = '0;
    logic              done;
    pal_pkg::pal_rsp_t rsp;

    pal_pkg::pal_req_t pending_ops[$];
    pal_pkg::pal_rsp_t expected_rsp[$];

    logic signed [pal_pkg::KEY_W-1:0] list_keys[CAPACITY];
    int                               list_count = 0;
    int                               plan_count = 0;
    int                               mismatches = 0;
    int                               idle_left = 0;
    logic                             accepted = 1'b0;

    positional_array_list #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always #2 clk = ~clk;

    function automatic pal_pkg::pal_rsp_t apply_list_op(pal_pkg::pal_req_t op);
        pal_pkg::pal_rsp_t r;
        int                pos;
        int                hit;
        r = '0;
        pos = op.position;
        hit = -1;
        r.status = pal_pkg::STATUS_OK;
        case (op.cmd)
            pal_pkg::CMD_CLEAR:
            begin
                list_count = 0;
            end
            pal_pkg::CMD_INSERT:
            begin
                if (list_count >= CAPACITY)
                begin
                    r.status = pal_pkg::STATUS_FULL;
                end
                else if (pos > list_count)
                begin
                    r.status = pal_pkg::STATUS_BAD_POS;
                end
                else
                begin
                    for (int i = list_count; i > pos; i--)
                    begin
                        list_keys[i] = list_keys[i-1];
                    end
                    list_keys[pos] = op.key;
                    list_count++;
                    r.entry_key = op.key;
                end
            end
            pal_pkg::CMD_REMOVE:
            begin
                if (pos >= list_count)
                begin
                    r.status = pal_pkg::STATUS_BAD_POS;
                end
                else
                begin
                    r.entry_key = list_keys[pos];
                    for (int i = pos; i + 1 < list_count; i++)
                    begin
                        list_keys[i] = list_keys[i+1];
                    end
                    list_count--;
                end
            end
            default:
            begin
                for (int i = 0; i < list_count; i++)
                begin
                    if (hit < 0 && list_keys[i] == op.key)
                    begin
                        hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    r.found_index = hit[6:0];
                    r.entry_key = op.key;
                end
                else
                begin
                    r.status = pal_pkg::STATUS_NOT_FOUND;
                end
            end
        endcase
        r.entry_count = list_count[7:0];
        return r;
    endfunction

    task automatic queue_op(logic [1:0] cmd, int pos, logic [31:0] key);
        pal_pkg::pal_req_t op;
        op.cmd = cmd;
        op.position = pos[7:0];
        op.key = key;
        pending_ops.push_back(op);
        case (cmd)
            pal_pkg::CMD_CLEAR:
            begin
                plan_count = 0;
            end
            pal_pkg::CMD_INSERT:
            begin
                if (plan_count < CAPACITY && op.position <= plan_count)
                begin
                    plan_count++;
                end
            end
            pal_pkg::CMD_REMOVE:
            begin
                if (op.position < plan_count)
                begin
                    plan_count--;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        logic [31:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            k = $urandom_range(0, 150) - 20;
        end
        else if (sel < 70)
        begin
            case ($urandom_range(0, 3))
                0: k = 32'h8000_0000;
                1: k = 32'h7FFF_FFFF;
                2: k = 32'h0000_0000;
                default: k = 32'hFFFF_FFFF;
            endcase
        end
        else
        begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic int pick_position(logic [1:0] cmd);
        int sel;
        int pos;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            pos = $urandom_range(0, 255);
        end
        else if (sel < 15)
        begin
            pos = (plan_count + $urandom_range(0, 1)) % 256;
        end
        else if (cmd == pal_pkg::CMD_INSERT)
        begin
            pos = $urandom_range(0, plan_count);
        end
        else if (cmd == pal_pkg::CMD_REMOVE && plan_count > 0)
        begin
            pos = $urandom_range(0, plan_count - 1);
        end
        else
        begin
            pos = $urandom_range(0, 255);
        end
        return pos;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || accepted)
            begin
                if (idle_left > 0)
                begin
                    start <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (pending_ops.size() > 0)
                begin
                    req <= pending_ops.pop_front();
                    start <= 1'b1;
                    if (pending_ops.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    begin
                        idle_left <= $urandom_range(1, 14);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    pal_pkg::pal_rsp_t exp_r;
                    exp_r = expected_rsp.pop_front();
                    if (rsp.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.found_index !== exp_r.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               exp_r.found_index, rsp.found_index);
                        mismatches++;
                    end
                    if (rsp.entry_key !== exp_r.entry_key)
                    begin
                        $error("entry_key: expected %0d, got %0d", exp_r.entry_key, rsp.entry_key);
                        mismatches++;
                    end
                    if (rsp.entry_count !== exp_r.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_r.entry_count, rsp.entry_count);
                        mismatches++;
                    end
                end
            end
            accepted <= start && !busy;
            if (start && !busy)
            begin
                expected_rsp.push_back(apply_list_op(req));
            end
        end
    end

    initial
    begin
        int weights[8][4];
        int sel;
        int phase;
        logic [1:0] cmd;

        weights = '{'{35, 25, 35, 5}, '{80, 5, 15, 0}, '{80, 5, 15, 0}, '{45, 15, 40, 0},
                    '{10, 70, 20, 0}, '{35, 25, 35, 5}, '{40, 35, 20, 5}, '{35, 25, 35, 5}};

        queue_op(pal_pkg::CMD_REMOVE, 0, 32'h0);
        queue_op(pal_pkg::CMD_SEARCH, 0, 32'h0);
        queue_op(pal_pkg::CMD_INSERT, 1, 32'h1);
        queue_op(pal_pkg::CMD_INSERT, 0, 32'h8000_0000);
        queue_op(pal_pkg::CMD_INSERT, 1, 32'h7FFF_FFFF);
        queue_op(pal_pkg::CMD_INSERT, 0, 32'hFFFF_FFFF);
        queue_op(pal_pkg::CMD_INSERT, 255, 32'h0);
        queue_op(pal_pkg::CMD_SEARCH, 0, 32'h7FFF_FFFF);
        queue_op(pal_pkg::CMD_SEARCH, 128, 32'h8000_0000);
        queue_op(pal_pkg::CMD_SEARCH, 0, 32'h0001_2345);
        queue_op(pal_pkg::CMD_INSERT, 3, 32'h0);
        queue_op(pal_pkg::CMD_INSERT, 1, 32'hFFFF_FFFF);
        queue_op(pal_pkg::CMD_SEARCH, 0, 32'hFFFF_FFFF);
        queue_op(pal_pkg::CMD_REMOVE, 5, 32'h0);
        queue_op(pal_pkg::CMD_REMOVE, 4, 32'h0);
        queue_op(pal_pkg::CMD_REMOVE, 0, 32'hFFFF_FFFF);
        queue_op(pal_pkg::CMD_REMOVE, 200, 32'h0);
        queue_op(pal_pkg::CMD_CLEAR, 255, 32'hFFFF_FFFF);
        queue_op(pal_pkg::CMD_SEARCH, 0, 32'hFFFF_FFFF);
        queue_op(pal_pkg::CMD_REMOVE, 0, 32'h0);
        queue_op(pal_pkg::CMD_INSERT, 0, 32'h5555_5555);
        queue_op(pal_pkg::CMD_INSERT, 0, 32'hAAAA_AAAA);
        queue_op(pal_pkg::CMD_SEARCH, 0, 32'h5555_5555);
        queue_op(pal_pkg::CMD_INSERT, 128, 32'h0);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            phase = (n / PHASE_LEN) % 8;
            sel = $urandom_range(0, 99);
            if (sel < weights[phase][0])
            begin
                cmd = pal_pkg::CMD_INSERT;
            end
            else if (sel < weights[phase][0] + weights[phase][1])
            begin
                cmd = pal_pkg::CMD_REMOVE;
            end
            else if (sel < weights[phase][0] + weights[phase][1] + weights[phase][2])
            begin
                cmd = pal_pkg::CMD_SEARCH;
            end
            else
            begin
                cmd = pal_pkg::CMD_CLEAR;
            end
            queue_op(cmd, pick_position(cmd), pick_key());
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() > 0 || start)
        begin
            @(posedge clk);
        end
        while (expected_rsp.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (CAPACITY / 8 + 8) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
